>>> sv/pmrq_pkg.sv
// Package: shared types and constants of the paged memory request queue.
`timescale 1ns / 1ps

package pmrq_pkg;

  // Defaults and fixed sizes
  localparam int unsigned DefQueueDepth = 16;
  localparam int unsigned MemBytes      = 2048;
  localparam int unsigned PageBytes     = 256;
  localparam logic [6:0]  BaseReset     = 7'd80;

  typedef logic [6:0] base_addr_t;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_DONE  = 2'd2,
    OP_ERROR = 2'd3
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_CMD   = 2'd1,
    KIND_CMPL  = 2'd2
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_ZCMPL,
    S_CMPL,
    S_LOAD,
    S_CMD,
    S_REPLY
  } state_e;

  typedef struct packed {
    op_e          operation;
    logic [10:0]  address;
    logic [11:0]  size;
    logic [15:0]  buffer_id;
    logic [15:0]  tag;
    logic         notify;
  } in_item_t;

  typedef struct packed {
    kind_e        kind;
    logic         status;
    logic [6:0]   device_address;
    logic [7:0]   page_offset;
    logic [8:0]   chunk_length;
    logic [10:0]  buffer_offset;
    logic [15:0]  buffer_ref;
    logic [15:0]  context_tag;
    logic         write_dir;
    logic         last;
  } out_item_t;

  // One queued request
  typedef struct packed {
    logic [10:0]  addr;
    logic [11:0]  len;
    logic [15:0]  buf_id;
    logic [15:0]  tag;
    logic         notify;
    logic         wr;
  } req_t;

endpackage

>>> sv/pmrq_stream_if.sv
// Interface: valid/ready channel with a typed payload.
`timescale 1ns / 1ps

interface pmrq_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/paged_memory_request_queue_top.sv
// Top level: request ring, page splitter and result sequencer of the request queue.
//
// Usage: requests and bus events enter on req_i (operation, address, size,
// buffer_id, tag, notify); results leave on rsp_o (submit replies, bus transfer
// commands, completions), up to two per input, the final one flagged by last.
// cfg_i writes the seven-bit device base address; write it only while idle.
// Items are handled one at a time by a sequencer. A done or error event may
// pop the next request, which is read from the ring memory into a register
// before it is loaded as the active request. Each result is registered in
// the output register; when the receiver stalls, the result holds there and
// the sequencer waits, so req_i stays low on ready until the final result of
// the current item has been loaded into the output register, where it may
// still be waiting for its transfer.
// Queued requests sit in a QUEUE_DEPTH entry synchronous memory; one slot is
// always kept empty. The active request and its byte count live in registers.
// Reset empties the ring, clears the active request and loads base address 80;
// the ring memory itself is not cleared, as only written entries are popped.
`timescale 1ns / 1ps

module paged_memory_request_queue_top #(
  parameter int unsigned QUEUE_DEPTH = pmrq_pkg::DefQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  pmrq_stream_if.sink   req_i,
  pmrq_stream_if.source rsp_o,
  pmrq_stream_if.sink   cfg_i
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);

  // Ring memory
  pmrq_pkg::req_t ring_mem [QUEUE_DEPTH];
  pmrq_pkg::req_t mem_rdata_q;
  logic           mem_we;
  logic           mem_re;

  // Control and datapath registers
  pmrq_pkg::state_e    state_q, state_d;
  logic [IdxW-1:0]     head_q, head_d;
  logic [IdxW-1:0]     tail_q, tail_d;
  logic                busy_q, busy_d;
  pmrq_pkg::req_t      act_q, act_d;
  logic [11:0]         moved_q, moved_d;
  pmrq_pkg::in_item_t  in_q;
  logic                rep_err_q, rep_err_d;
  logic                cmpl_err_q, cmpl_err_d;
  logic                cmd_rep_q, cmd_rep_d;
  pmrq_pkg::base_addr_t base_q;
  pmrq_pkg::out_item_t out_q, out_d;
  logic                out_vld_q, out_vld_d;

  // Combinational helpers
  pmrq_pkg::req_t      in_req;
  logic [12:0]         end_addr;
  logic [11:0]         cur;
  logic [8:0]          room;
  logic [11:0]         rem;
  logic [8:0]          chunk;
  logic [11:0]         new_moved;
  logic [IdxW-1:0]     head_nxt;
  logic [IdxW-1:0]     tail_nxt;
  logic                ring_empty;
  logic                slot_free;
  logic                emit;
  pmrq_pkg::out_item_t emit_item;

  // Build a reply or completion result, transfer fields zero
  function automatic pmrq_pkg::out_item_t mk_plain(pmrq_pkg::kind_e k, logic st,
                                                   logic [15:0] b, logic [15:0] t,
                                                   logic w, logic l);
    pmrq_pkg::out_item_t o;
    o = '0;
    o.kind        = k;
    o.status      = st;
    o.buffer_ref  = b;
    o.context_tag = t;
    o.write_dir   = w;
    o.last        = l;
    return o;
  endfunction

  // Request as given by the latched submit
  always_comb begin
    in_req.addr   = in_q.address;
    in_req.len    = in_q.size;
    in_req.buf_id = in_q.buffer_id;
    in_req.tag    = in_q.tag;
    in_req.notify = in_q.notify;
    in_req.wr     = (in_q.operation == pmrq_pkg::OP_WRITE);
  end

  // Page split of the active request
  assign end_addr  = {2'b00, in_q.address} + {1'b0, in_q.size};
  assign cur       = {1'b0, act_q.addr} + moved_q;
  assign room      = 9'(pmrq_pkg::PageBytes) - {1'b0, cur[7:0]};
  assign rem       = act_q.len - moved_q;
  assign chunk     = (rem < {3'b000, room}) ? rem[8:0] : room;
  assign new_moved = moved_q + {3'b000, chunk};

  // Ring pointers
  assign head_nxt   = (head_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt   = (tail_q == IdxW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign ring_empty = (head_q == tail_q);

  assign slot_free   = !out_vld_q || rsp_o.ready;
  assign req_i.ready = (state_q == pmrq_pkg::S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign rsp_o.valid   = out_vld_q;
  assign rsp_o.payload = out_q;

  // Next state, pointer updates and result selection
  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    tail_d     = tail_q;
    busy_d     = busy_q;
    act_d      = act_q;
    moved_d    = moved_q;
    rep_err_d  = rep_err_q;
    cmpl_err_d = cmpl_err_q;
    cmd_rep_d  = cmd_rep_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    emit       = 1'b0;
    emit_item  = '0;

    unique case (state_q)
      pmrq_pkg::S_IDLE: begin
        if (req_i.valid) begin
          state_d = pmrq_pkg::S_EVAL;
        end
      end

      pmrq_pkg::S_EVAL: begin
        priority if (in_q.operation == pmrq_pkg::OP_WRITE ||
                     in_q.operation == pmrq_pkg::OP_READ) begin
          priority if (end_addr > 13'(pmrq_pkg::MemBytes)) begin
            rep_err_d = 1'b1;
            state_d   = pmrq_pkg::S_REPLY;
          end else if (in_q.size == '0) begin
            rep_err_d = 1'b0;
            state_d   = in_q.notify ? pmrq_pkg::S_ZCMPL : pmrq_pkg::S_REPLY;
          end else if (head_nxt == tail_q) begin
            rep_err_d = 1'b1;
            state_d   = pmrq_pkg::S_REPLY;
          end else if (busy_q) begin
            // queue behind the active request
            mem_we    = 1'b1;
            head_d    = head_nxt;
            rep_err_d = 1'b0;
            state_d   = pmrq_pkg::S_REPLY;
          end else begin
            // ring is empty while idle: start the request straight away
            act_d     = in_req;
            moved_d   = '0;
            busy_d    = 1'b1;
            rep_err_d = 1'b0;
            cmd_rep_d = 1'b1;
            state_d   = pmrq_pkg::S_CMD;
          end
        end else if (!busy_q) begin
          state_d = pmrq_pkg::S_IDLE;
        end else if (in_q.operation == pmrq_pkg::OP_DONE) begin
          if (new_moved >= act_q.len) begin
            busy_d     = 1'b0;
            cmpl_err_d = 1'b0;
            state_d    = pmrq_pkg::S_CMPL;
          end else begin
            moved_d   = new_moved;
            cmd_rep_d = 1'b0;
            state_d   = pmrq_pkg::S_CMD;
          end
        end else begin
          busy_d     = 1'b0;
          cmpl_err_d = 1'b1;
          state_d    = pmrq_pkg::S_CMPL;
        end
      end

      pmrq_pkg::S_ZCMPL: begin
        emit      = 1'b1;
        emit_item = mk_plain(pmrq_pkg::KIND_CMPL, 1'b0, in_q.buffer_id, in_q.tag,
                             in_req.wr, 1'b0);
        if (slot_free) begin
          state_d = pmrq_pkg::S_REPLY;
        end
      end

      pmrq_pkg::S_CMPL: begin
        emit      = act_q.notify;
        emit_item = mk_plain(pmrq_pkg::KIND_CMPL, cmpl_err_q, act_q.buf_id, act_q.tag,
                             act_q.wr, ring_empty);
        if (slot_free || !act_q.notify) begin
          // pop the next request, if any
          if (ring_empty) begin
            state_d = pmrq_pkg::S_IDLE;
          end else begin
            mem_re  = 1'b1;
            tail_d  = tail_nxt;
            state_d = pmrq_pkg::S_LOAD;
          end
        end
      end

      pmrq_pkg::S_LOAD: begin
        act_d     = mem_rdata_q;
        moved_d   = '0;
        busy_d    = 1'b1;
        cmd_rep_d = 1'b0;
        state_d   = pmrq_pkg::S_CMD;
      end

      pmrq_pkg::S_CMD: begin
        emit                     = 1'b1;
        emit_item                = '0;
        emit_item.kind           = pmrq_pkg::KIND_CMD;
        emit_item.device_address = base_q | {4'b0000, cur[10:8]};
        emit_item.page_offset    = cur[7:0];
        emit_item.chunk_length   = chunk;
        emit_item.buffer_offset  = moved_q[10:0];
        emit_item.buffer_ref     = act_q.buf_id;
        emit_item.context_tag    = act_q.tag;
        emit_item.write_dir      = act_q.wr;
        emit_item.last           = !cmd_rep_q;
        if (slot_free) begin
          state_d = cmd_rep_q ? pmrq_pkg::S_REPLY : pmrq_pkg::S_IDLE;
        end
      end

      pmrq_pkg::S_REPLY: begin
        emit      = 1'b1;
        emit_item = mk_plain(pmrq_pkg::KIND_REPLY, rep_err_q, in_q.buffer_id, in_q.tag,
                             in_req.wr, 1'b1);
        if (slot_free) begin
          state_d = pmrq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = pmrq_pkg::S_IDLE;
      end
    endcase

    // Output register: load on a free slot, drop once transferred
    out_d     = out_q;
    out_vld_d = out_vld_q && !rsp_o.ready;
    if (emit && slot_free) begin
      out_d     = emit_item;
      out_vld_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pmrq_pkg::S_IDLE;
      head_q     <= '0;
      tail_q     <= '0;
      busy_q     <= 1'b0;
      act_q      <= '0;
      moved_q    <= '0;
      rep_err_q  <= 1'b0;
      cmpl_err_q <= 1'b0;
      cmd_rep_q  <= 1'b0;
      out_vld_q  <= 1'b0;
      base_q     <= pmrq_pkg::BaseReset;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      tail_q     <= tail_d;
      busy_q     <= busy_d;
      act_q      <= act_d;
      moved_q    <= moved_d;
      rep_err_q  <= rep_err_d;
      cmpl_err_q <= cmpl_err_d;
      cmd_rep_q  <= cmd_rep_d;
      out_vld_q  <= out_vld_d;
      if (cfg_i.valid) begin
        base_q <= cfg_i.payload;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (req_i.valid && req_i.ready) begin
      in_q <= req_i.payload;
    end
  end

  // Ring memory: write at head, read at tail; never the same cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[head_q] <= in_req;
    end
    if (mem_re) begin
      mem_rdata_q <= ring_mem[tail_q];
    end
  end

  // Idle with no transfer in flight means the ring is empty
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pmrq_pkg::S_IDLE && !busy_q) |-> (head_q == tail_q))
    else $error("idle with requests left in the ring");

  // A command never leaves an empty or page-crossing chunk
  a_cmd_chunk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && state_q == pmrq_pkg::S_CMD) |->
      (chunk != '0 && ({1'b0, cur[7:0]} + chunk) <= 9'(pmrq_pkg::PageBytes)))
    else $error("bad transfer chunk");

  // A command is only issued for an active request
  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pmrq_pkg::S_CMD) |-> busy_q)
    else $error("command without active request");

  // A pop is followed by the load of the read data
  a_pop_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |=> (state_q == pmrq_pkg::S_LOAD && !busy_q))
    else $error("ring read not followed by load");

endmodule
